// File: design/sfi_pkg.sv
package sfi_pkg;

    // Field and state widths.
    localparam int STATE_W  = 2;    // state index field
    localparam int LEN_W    = 24;   // ticks: frame length, offset and dwell
    localparam int CNT_W    = 21;   // frame count and frames done
    localparam int IDX_W    = 20;   // frame index field
    localparam int EMIT_W   = 16;   // emission level and frame value
    localparam int POS_W    = 26;   // signed position inside the open frame
    localparam int SUM_W    = 41;   // signed emission * ticks of one frame
    localparam int CFG_W    = 24;   // configuration write data

    // Number of emission registers that the state index can address.
    localparam int NUM_EMISSION_REGS = 2 ** STATE_W;

    // Frames that one segment may close before it is clipped.
    localparam int MAX_FRAMES = 64;
    localparam int SLOT_W     = $clog2(MAX_FRAMES);
    localparam int RES_W      = SLOT_W + 1;

    // Largest frame count that takes effect.
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(1048576);

    // Configuration register indexes.
    typedef logic [2:0] cfg_addr_t;
    localparam cfg_addr_t CFG_FRAME_LENGTH = 3'd0;
    localparam cfg_addr_t CFG_FRAME_OFFSET = 3'd1;
    localparam cfg_addr_t CFG_FRAME_COUNT  = 3'd2;
    localparam cfg_addr_t CFG_EMISSION_0   = 3'd3;

    // Reset values of the timing registers.
    localparam logic [LEN_W-1:0] FRAME_LENGTH_RESET = LEN_W'(1000);
    localparam logic [LEN_W-1:0] FRAME_OFFSET_RESET = '0;
    localparam logic [CNT_W-1:0] FRAME_COUNT_RESET  = CNT_W'(1024);

    // Input transaction: one trace segment.
    typedef struct packed {
        logic [STATE_W-1:0] state_index;
        logic [LEN_W-1:0]   dwell;
    } segment_t;

    // Output transaction: one closed frame.
    typedef struct packed {
        logic [IDX_W-1:0]         frame_index;
        logic signed [EMIT_W-1:0] frame_value;
        logic                     last;
        logic                     clipped;
    } frame_t;

    // Frame result as held in the result buffer.
    typedef struct packed {
        logic [IDX_W-1:0]         frame_index;
        logic signed [EMIT_W-1:0] frame_value;
    } frame_entry_t;

endpackage

// File: design/sfi_ram.sv
module sfi_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/sfi_divider.sv
module sfi_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [sfi_pkg::SUM_W-1:0] dividend,
    input  logic [sfi_pkg::LEN_W-1:0]        divisor,
    output logic                             done,
    output logic signed [sfi_pkg::EMIT_W-1:0] quotient
);

    import sfi_pkg::*;

    localparam int STEP_W = $clog2(EMIT_W);

    logic                  busy_reg,    busy_next;
    logic                  done_reg,    done_next;
    logic [STEP_W-1:0]     step_reg,    step_next;
    logic [LEN_W-1:0]      partial_reg, partial_next;
    logic [EMIT_W-1:0]     low_reg,     low_next;
    logic [LEN_W-1:0]      divisor_reg, divisor_next;
    logic                  neg_reg,     neg_next;

    logic [SUM_W-1:0]      magnitude;
    logic [LEN_W+1:0]      trial;
    logic                  fits;

    // Magnitude of the dividend; the quotient is truncated toward zero.
    assign magnitude = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {1'b0, partial_reg, low_reg[EMIT_W-1]} - {2'b00, divisor_reg};
    assign fits  = !trial[LEN_W+1];

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        partial_next = partial_reg;
        low_next     = low_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        if (start)
        begin
            // The quotient fits in EMIT_W bits, so the upper part is below the divisor.
            busy_next    = 1'b1;
            step_next    = '0;
            partial_next = magnitude[EMIT_W +: LEN_W];
            low_next     = magnitude[EMIT_W-1:0];
            divisor_next = divisor;
            neg_next     = dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            partial_next = fits ? trial[LEN_W-1:0]
                                : {partial_reg[LEN_W-2:0], low_reg[EMIT_W-1]};
            low_next     = {low_reg[EMIT_W-2:0], fits};
            step_next    = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(EMIT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        partial_reg <= partial_next;
        low_reg     <= low_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(EMIT_W'(-low_reg)) : $signed(low_reg);

endmodule

// File: design/segment_to_frame_integrator.sv
// Bins a stream of trace segments (a state and a dwell in ticks) into frames of
// frame_length ticks, starting frame_offset ticks into the trace, and delivers
// for each closed frame the time-weighted mean emission, truncated toward zero.
// A frame closes only when a segment reaches strictly past its end; one segment
// closes at most 64 frames, and a segment that would close more is clipped and
// all of its results carry the clipped flag. After frame_count frames the block
// stays silent until a timing register is written, which restarts integration.
// Each frame that a segment closes goes through one shared multiplier and a
// 16-step bit-serial divider, its result is parked in a 64-entry buffer, and
// the buffer is read out one frame at a time, a read step then a load step that
// waits for the output register, once the segment is done, so that the clipped
// flag is known before the first result leaves. A new segment is accepted once
// the last result has moved to the output register.
module segment_to_frame_integrator #(
    parameter int NUM_STATES = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  sfi_pkg::cfg_addr_t            cfg_index,
    input  logic [sfi_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          seg_valid,
    output logic                          seg_ready,
    input  sfi_pkg::segment_t             seg,
    output logic                          frame_valid,
    input  logic                          frame_ready,
    output sfi_pkg::frame_t               frame
);

    import sfi_pkg::*;

    localparam int NUM_EMIT = (NUM_STATES < NUM_EMISSION_REGS) ? NUM_STATES
                                                               : NUM_EMISSION_REGS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SKIP,
        S_CHECK,
        S_MULT,
        S_ACC,
        S_DIV,
        S_TMULT,
        S_TACC,
        S_RD,
        S_LOAD
    } state_t;

    // Configuration registers.
    logic [LEN_W-1:0]         frame_length_reg;
    logic [LEN_W-1:0]         frame_offset_reg;
    logic [CNT_W-1:0]         frame_count_reg;
    logic signed [EMIT_W-1:0] emission_reg [NUM_EMIT];

    // Integration state and sequencer.
    state_t                   state_reg,   state_next;
    logic signed [SUM_W-1:0]  sum_reg,     sum_next;
    logic signed [POS_W-1:0]  pos_reg,     pos_next;
    logic [CNT_W-1:0]         done_reg,    done_next;
    logic [LEN_W-1:0]         rem_reg,     rem_next;
    logic signed [EMIT_W-1:0] level_reg,   level_next;
    logic [LEN_W-1:0]         mul_a_reg,   mul_a_next;
    logic signed [SUM_W-1:0]  prod_reg,    prod_next;
    logic [RES_W-1:0]         n_reg,       n_next;
    logic [SLOT_W-1:0]        rd_idx_reg,  rd_idx_next;
    logic                     clip_reg,    clip_next;
    logic                     out_valid_reg, out_valid_next;
    frame_t                   out_reg,     out_next;

    logic [LEN_W-1:0]         len_eff;
    logic [CNT_W-1:0]         limit_eff;
    logic                     finished;
    logic signed [EMIT_W-1:0] level_sel;
    logic signed [POS_W:0]    reach;
    logic                     beyond;
    logic [LEN_W-1:0]         take;
    logic [LEN_W-1:0]         neg_pos;
    logic [LEN_W-1:0]         skip;
    logic signed [SUM_W-1:0]  product;
    logic signed [SUM_W-1:0]  acc_sum;
    logic                     div_start;
    logic                     div_done;
    logic signed [EMIT_W-1:0] div_quotient;
    logic                     ram_we;
    frame_entry_t             ram_wdata;
    frame_entry_t             ram_rdata;
    logic                     is_last;
    logic                     timing_write;

    // Effective frame length and frame count.
    assign len_eff   = (frame_length_reg == '0) ? LEN_W'(1) : frame_length_reg;
    assign limit_eff = (frame_count_reg > COUNT_MAX) ? COUNT_MAX : frame_count_reg;
    assign finished  = (done_reg >= limit_eff);

    // Emission of the incoming segment; unused states emit zero.
    always_comb
    begin
        level_sel = '0;
        for (int i = 0; i < NUM_EMIT; i++)
        begin
            if (seg.state_index == STATE_W'(i))
            begin
                level_sel = emission_reg[i];
            end
        end
    end

    // Position tests of the open frame.
    assign reach   = {pos_reg[POS_W-1], pos_reg} + $signed({3'b000, rem_reg});
    assign beyond  = (reach > $signed({3'b000, len_eff}));
    assign take    = (pos_reg < $signed({2'b00, len_eff})) ? len_eff - pos_reg[LEN_W-1:0]
                                                           : '0;
    assign neg_pos = LEN_W'(-pos_reg);
    assign skip    = (neg_pos < rem_reg) ? neg_pos : rem_reg;

    // Shared multiplier: ticks times level, sign-extended to the sum width.
    assign product = $signed({1'b0, mul_a_reg}) * level_reg;
    assign acc_sum = sum_reg + prod_reg;

    assign div_start = (state_reg == S_ACC);
    assign is_last   = ({1'b0, rd_idx_reg} == n_reg - RES_W'(1));
    assign timing_write = cfg_we && (cfg_index == CFG_FRAME_LENGTH ||
                                     cfg_index == CFG_FRAME_OFFSET ||
                                     cfg_index == CFG_FRAME_COUNT);

    sfi_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_sum),
        .divisor  (len_eff),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign ram_we    = (state_reg == S_DIV) && div_done;
    assign ram_wdata = '{frame_index: done_reg[IDX_W-1:0], frame_value: div_quotient};

    sfi_ram #(
        .WIDTH ($bits(frame_entry_t)),
        .DEPTH (MAX_FRAMES)
    ) u_result_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (n_reg[SLOT_W-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        done_next      = done_reg;
        rem_next       = rem_reg;
        level_next     = level_reg;
        mul_a_next     = mul_a_reg;
        prod_next      = prod_reg;
        n_next         = n_reg;
        rd_idx_next    = rd_idx_reg;
        clip_next      = clip_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // The output register empties when its transaction completes.
        if (out_valid_reg && frame_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (seg_valid)
                begin
                    level_next = level_sel;
                    rem_next   = seg.dwell;
                    n_next     = '0;
                    clip_next  = 1'b0;
                    state_next = finished ? S_IDLE : S_SKIP;
                end
            end
            S_SKIP:
            begin
                // Ticks before the first frame add nothing.
                if (pos_reg < 0)
                begin
                    pos_next = pos_reg + $signed({2'b00, skip});
                    rem_next = rem_reg - skip;
                end
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (beyond && finished)
                begin
                    rem_next   = '0;
                    mul_a_next = '0;
                    state_next = S_TMULT;
                end
                else if (beyond && n_reg == RES_W'(MAX_FRAMES))
                begin
                    clip_next  = 1'b1;
                    rem_next   = '0;
                    mul_a_next = '0;
                    state_next = S_TMULT;
                end
                else if (beyond)
                begin
                    mul_a_next = take;
                    state_next = S_MULT;
                end
                else
                begin
                    mul_a_next = rem_reg;
                    state_next = S_TMULT;
                end
            end
            S_MULT:
            begin
                prod_next  = product;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                // The divider takes the completed frame sum in this cycle.
                sum_next   = acc_sum;
                rem_next   = rem_reg - mul_a_reg;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    n_next     = n_reg + RES_W'(1);
                    done_next  = done_reg + CNT_W'(1);
                    sum_next   = '0;
                    pos_next   = '0;
                    state_next = S_CHECK;
                end
            end
            S_TMULT:
            begin
                prod_next  = product;
                state_next = S_TACC;
            end
            S_TACC:
            begin
                // The rest of the segment stays in the open frame.
                sum_next    = acc_sum;
                pos_next    = pos_reg + $signed({2'b00, mul_a_reg});
                rd_idx_next = '0;
                state_next  = (n_reg != '0) ? S_RD : S_IDLE;
            end
            S_RD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (!out_valid_reg || frame_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{frame_index: ram_rdata.frame_index,
                                       frame_value: ram_rdata.frame_value,
                                       last:        is_last,
                                       clipped:     clip_reg};
                    rd_idx_next    = rd_idx_reg + SLOT_W'(1);
                    state_next     = is_last ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A timing register write restarts integration.
        if (timing_write)
        begin
            sum_next  = '0;
            done_next = '0;
            pos_next  = (cfg_index == CFG_FRAME_OFFSET)
                        ? POS_W'(0) - $signed({2'b00, cfg_data[LEN_W-1:0]})
                        : POS_W'(0) - $signed({2'b00, frame_offset_reg});
        end
    end

    // State, counters and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            pos_reg       <= POS_W'(0) - $signed({2'b00, FRAME_OFFSET_RESET});
            done_reg      <= '0;
            n_reg         <= '0;
            rd_idx_reg    <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            done_reg      <= done_next;
            n_reg         <= n_next;
            rd_idx_reg    <= rd_idx_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working operands and output payload.
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        level_reg <= level_next;
        mul_a_reg <= mul_a_next;
        prod_reg  <= prod_next;
        out_reg   <= out_next;
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FRAME_LENGTH_RESET;
            frame_offset_reg <= FRAME_OFFSET_RESET;
            frame_count_reg  <= FRAME_COUNT_RESET;
            for (int i = 0; i < NUM_EMIT; i++)
            begin
                emission_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FRAME_LENGTH)
            begin
                frame_length_reg <= cfg_data[LEN_W-1:0];
            end
            if (cfg_index == CFG_FRAME_OFFSET)
            begin
                frame_offset_reg <= cfg_data[LEN_W-1:0];
            end
            if (cfg_index == CFG_FRAME_COUNT)
            begin
                frame_count_reg <= cfg_data[CNT_W-1:0];
            end
            for (int i = 0; i < NUM_EMIT; i++)
            begin
                if (cfg_index == 3'(CFG_EMISSION_0 + i))
                begin
                    emission_reg[i] <= $signed(cfg_data[EMIT_W-1:0]);
                end
            end
        end
    end

    assign seg_ready   = (state_reg == S_IDLE);
    assign frame_valid = out_valid_reg;
    assign frame       = out_reg;

`ifndef NO_ASSERTIONS
    // The result buffer never holds more than one segment's worth of frames.
    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= RES_W'(MAX_FRAMES))
    else $error("result count exceeds buffer depth");

    // No more frames are closed than the frame count allows.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg <= limit_eff)
    else $error("frames done beyond frame count");

    // Between segments the open frame never extends past its end.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> pos_reg <= $signed({2'b00, len_eff}))
    else $error("open frame position past frame length");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
    else $error("divider result arrived outside the divide step");

    // A new output transaction is only loaded from the result buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_LOAD))
    else $error("output loaded outside the readout step");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

import sfi_pkg::*;

// Tracks the block's integration state, predicts the frames that each
// accepted segment closes, and checks the frames that leave the block.
class frame_scoreboard;

    localparam int MAX_PRINTED = 40;

    // Copy of the programmed registers.
    logic [LEN_W-1:0]         frame_len;
    logic [LEN_W-1:0]         frame_off;
    logic [CNT_W-1:0]         frame_cnt;
    logic signed [EMIT_W-1:0] level [NUM_EMISSION_REGS];

    // Integration state of the open frame.
    longint      open_sum;
    longint      open_pos;
    int unsigned frames_done;

    frame_t expected_frames [$];

    int mismatches;
    int frames_checked;
    int clipped_segments;

    function new();
        frame_len = FRAME_LENGTH_RESET;
        frame_off = FRAME_OFFSET_RESET;
        frame_cnt = FRAME_COUNT_RESET;
        foreach (level[k])
            level[k] = '0;
        mismatches       = 0;
        frames_checked   = 0;
        clipped_segments = 0;
        restart();
    endfunction

    function void restart();
        open_sum    = 0;
        open_pos    = -longint'(frame_off);
        frames_done = 0;
    endfunction

    function longint effective_length();
        return (frame_len == '0) ? 1 : longint'(frame_len);
    endfunction

    // A timing register write restarts integration; emission writes do not.
    function void write_register(cfg_addr_t idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_FRAME_LENGTH:
            begin
                frame_len = data[LEN_W-1:0];
                restart();
            end
            CFG_FRAME_OFFSET:
            begin
                frame_off = data[LEN_W-1:0];
                restart();
            end
            CFG_FRAME_COUNT:
            begin
                frame_cnt = data[CNT_W-1:0];
                restart();
            end
            default:
            begin
                if (idx >= CFG_EMISSION_0 && idx < CFG_EMISSION_0 + NUM_EMISSION_REGS)
                    level[idx - CFG_EMISSION_0] = data[EMIT_W-1:0];
            end
        endcase
    endfunction

    // Works out the frames that one segment closes. Returns 0 when the frame
    // budget is already spent and the segment is ignored.
    function bit integrate_segment(segment_t s);
        longint      rem;
        longint      len;
        longint      take;
        longint      lvl;
        int unsigned budget;
        bit          clip;
        frame_t      closed [$];
        frame_t      f;

        rem    = longint'(s.dwell);
        len    = effective_length();
        budget = 32'((frame_cnt > COUNT_MAX) ? COUNT_MAX : frame_cnt);
        clip   = 1'b0;
        if (frames_done >= budget)
            return 1'b0;
        lvl = longint'(level[s.state_index]);

        // Ticks before the first frame add nothing.
        if (open_pos < 0)
        begin
            take = (-open_pos > rem) ? rem : -open_pos;
            open_pos += take;
            rem      -= take;
        end

        // Close every frame that the segment reaches strictly beyond.
        while (open_pos + rem > len)
        begin
            if (frames_done >= budget)
            begin
                rem = 0;
                break;
            end
            if (closed.size() == MAX_FRAMES)
            begin
                clip = 1'b1;
                rem  = 0;
                break;
            end
            take      = (open_pos < len) ? len - open_pos : 0;
            open_sum += take * lvl;
            rem      -= take;
            f.frame_index = IDX_W'(frames_done);
            f.frame_value = EMIT_W'(open_sum / len);
            f.last        = 1'b0;
            f.clipped     = 1'b0;
            closed.push_back(f);
            frames_done++;
            open_sum = 0;
            open_pos = 0;
        end
        open_sum += rem * lvl;
        open_pos += rem;

        if (clip)
            clipped_segments++;
        foreach (closed[k])
        begin
            closed[k].last    = (k == closed.size() - 1);
            closed[k].clipped = clip;
            expected_frames.push_back(closed[k]);
        end
        return 1'b1;
    endfunction

    task report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns: frame mismatch, %s", $time, what);
    endtask

    // Compares one accepted frame with the oldest prediction.
    task check_frame(frame_t got);
        frame_t want;

        if (expected_frames.size() == 0)
        begin
            report_mismatch($sformatf("unexpected frame %0d value %0d",
                                      got.frame_index, got.frame_value));
            return;
        end
        want = expected_frames.pop_front();
        frames_checked++;
        if (got.frame_index !== want.frame_index)
            report_mismatch($sformatf("frame_index %0d, predicted %0d",
                                      got.frame_index, want.frame_index));
        if (got.frame_value !== want.frame_value)
            report_mismatch($sformatf("frame %0d frame_value %0d, predicted %0d",
                                      want.frame_index, got.frame_value, want.frame_value));
        if (got.last !== want.last)
            report_mismatch($sformatf("frame %0d last %b, predicted %b",
                                      want.frame_index, got.last, want.last));
        if (got.clipped !== want.clipped)
            report_mismatch($sformatf("frame %0d clipped %b, predicted %b",
                                      want.frame_index, got.clipped, want.clipped));
    endtask

    function int pending();
        return expected_frames.size();
    endfunction

endclass

module tb;

    localparam int NUM_REGS        = 2 ** $bits(cfg_addr_t);
    localparam int RANDOM_ITEMS    = 500;
    localparam int IDLE_PERCENT    = 22;
    localparam int SETTLE_CYCLES   = 100;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int PRESSURE_PHASE  = 1;
    localparam int STEADY_PHASE    = 3;

    localparam cfg_addr_t CFG_UNUSED = cfg_addr_t'(NUM_REGS - 1);
    localparam logic [NUM_REGS-1:0] TIMING_REGS =
        NUM_REGS'((1 << CFG_FRAME_LENGTH) | (1 << CFG_FRAME_OFFSET) | (1 << CFG_FRAME_COUNT));
    localparam logic [NUM_REGS-1:0] EMISSION_REGS =
        NUM_REGS'(((1 << NUM_EMISSION_REGS) - 1) << CFG_EMISSION_0);

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    cfg_addr_t        cfg_index = CFG_FRAME_LENGTH;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             seg_valid = 1'b0;
    logic             seg_ready;
    segment_t         seg       = '0;
    logic             frame_valid;
    logic             frame_ready = 1'b0;
    frame_t           frame;

    frame_scoreboard scoreboard = new();

    // Shared between the stimulus and the frame sink.
    bit no_idle   = 1'b0;
    bit want_hold = 1'b0;

    int segments_sent    = 0;
    int segments_ignored = 0;
    int settings_used    = 0;

    segment_to_frame_integrator uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Writes the selected registers, one per cycle, then drops the enable.
    task automatic program_regs(input logic [CFG_W-1:0] vals [NUM_REGS],
                                input logic [NUM_REGS-1:0] mask);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (mask[i])
            begin
                cfg_we    <= 1'b1;
                cfg_index <= cfg_addr_t'(i);
                cfg_data  <= vals[i];
                @(posedge clk);
                scoreboard.write_register(cfg_addr_t'(i), vals[i]);
            end
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Offers one segment transaction, after a random gap, until accepted.
    task automatic send_segment(input logic [STATE_W-1:0] st, input logic [LEN_W-1:0] dw);
        segment_t s;

        s.state_index = st;
        s.dwell       = dw;
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            seg_valid <= 1'b0;
            @(posedge clk);
        end
        seg_valid <= 1'b1;
        seg       <= s;
        @(posedge clk);
        while (!seg_ready)
            @(posedge clk);
        segments_sent++;
        if (!scoreboard.integrate_segment(s))
            segments_ignored++;
    endtask

    // Lets the block drain and go idle before the next register writes.
    task automatic settle();
        seg_valid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly a few frames per segment, with zero dwells, whole multiples of the
    // frame, lengths around the clipping point and full-range dwells mixed in.
    function automatic logic [LEN_W-1:0] pick_dwell(longint len);
        longint      d;
        int unsigned pick;

        pick = $urandom_range(99);
        if (pick < 5)
            d = 0;
        else if (pick < 10)
            d = longint'($urandom_range(0, 24'hFFFFFF));
        else if (pick < 18)
            d = len * $urandom_range(63, 66) + $urandom_range(0, 2);
        else if (pick < 25)
            d = len * $urandom_range(1, 4);
        else
            d = longint'($urandom_range(0, 32'(3 * len)));
        if (d > 24'hFFFFFF)
            d = 24'hFFFFFF;
        return LEN_W'(d);
    endfunction

    // Emission levels lean toward full scale; the unused upper data bits are random.
    function automatic logic [CFG_W-1:0] pick_level();
        logic [EMIT_W-1:0] lvl;
        int unsigned       pick;

        pick = $urandom_range(99);
        if (pick < 15)
            lvl = 16'h7FFF;
        else if (pick < 30)
            lvl = 16'h8000;
        else if (pick < 35)
            lvl = '0;
        else
            lvl = EMIT_W'($urandom());
        return {(CFG_W - EMIT_W)'($urandom()), lvl};
    endfunction

    // Frame sink: checks each accepted frame and drives a random ready, with
    // one long hold-off on request.
    initial
    begin : frame_sink
        int hold_left;
        bit hold_taken;

        hold_left  = 0;
        hold_taken = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (frame_valid && frame_ready)
                scoreboard.check_frame(frame);
            if (want_hold && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                frame_ready <= 1'b0;
            end
            else
                frame_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0]    vals [NUM_REGS];
        logic [NUM_REGS-1:0] mask;
        int                  phase;
        int                  n_items;
        int unsigned         pick;
        longint              eff_len;
        longint              off;

        foreach (vals[k])
            vals[k] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-scale and other emissions written without a restart, then a segment of zero
        // dwell, two that together end exactly on the frame end, one that closes that frame
        // with no further ticks, and a full-range dwell that gets clipped.
        vals[CFG_EMISSION_0 + 0] = 24'h00_7FFF;
        vals[CFG_EMISSION_0 + 1] = 24'hAB_8000;
        vals[CFG_EMISSION_0 + 2] = 24'h00_04D2;
        vals[CFG_EMISSION_0 + 3] = 24'h00_FFF9;
        program_regs(vals, EMISSION_REGS);
        send_segment(2'd0, 24'd0);
        send_segment(2'd1, 24'd999);
        send_segment(2'd2, 24'd1);
        send_segment(2'd3, 24'd1);
        send_segment(2'd0, 24'hFFFFFF);
        send_segment(2'd1, 24'd2500);
        settle();

        // Zero frame length acts as one tick; a short lead-in and a budget of three
        // frames, after which segments are ignored.
        vals[CFG_FRAME_LENGTH] = '0;
        vals[CFG_FRAME_OFFSET] = 24'd5;
        vals[CFG_FRAME_COUNT]  = 24'd3;
        program_regs(vals, TIMING_REGS);
        send_segment(2'd0, 24'd3);
        send_segment(2'd1, 24'd4);
        send_segment(2'd2, 24'd10);
        send_segment(2'd3, 24'd100);
        settle();

        // Longest frame and lead-in, and a frame count above the cap.
        vals[CFG_FRAME_LENGTH] = 24'hFFFFFF;
        vals[CFG_FRAME_OFFSET] = 24'hFFFFFF;
        vals[CFG_FRAME_COUNT]  = 24'hFFFFFF;
        program_regs(vals, TIMING_REGS);
        send_segment(2'd3, 24'hFFFFFF);
        send_segment(2'd0, 24'hFFFFFF);
        send_segment(2'd1, 24'd1);
        send_segment(2'd2, 24'hFFFFFF);
        settle();

        // A zero frame count yields nothing; the unused register index is written too.
        vals[CFG_FRAME_LENGTH] = 24'd1;
        vals[CFG_FRAME_OFFSET] = '0;
        vals[CFG_FRAME_COUNT]  = '0;
        vals[CFG_UNUSED]       = 24'hFFFFFF;
        program_regs(vals, NUM_REGS'(TIMING_REGS | (1 << CFG_UNUSED)));
        send_segment(2'd0, 24'd500);
        send_segment(2'd3, 24'd7);
        settle();

        // Random phases, each with its own register setting.
        phase = 0;
        while (segments_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                vals[CFG_FRAME_LENGTH] = '0;
            else if (pick < 10)
                vals[CFG_FRAME_LENGTH] = 24'hFFFFFF;
            else if (pick < 25)
                vals[CFG_FRAME_LENGTH] = CFG_W'($urandom_range(1, 24'hFFFFFF));
            else
                vals[CFG_FRAME_LENGTH] = CFG_W'($urandom_range(1, 40));
            eff_len = (vals[CFG_FRAME_LENGTH] == '0) ? 1 : longint'(vals[CFG_FRAME_LENGTH]);

            pick = $urandom_range(99);
            if (pick < 40)
                off = 0;
            else if (pick < 80)
                off = longint'($urandom_range(1, 32'(3 * eff_len)));
            else if (pick < 90)
                off = 24'hFFFFFF;
            else
                off = longint'($urandom_range(0, 24'hFFFFFF));
            vals[CFG_FRAME_OFFSET] = (off > 24'hFFFFFF) ? 24'hFFFFFF : CFG_W'(off);

            pick = $urandom_range(99);
            if (pick < 5)
                vals[CFG_FRAME_COUNT] = '0;
            else if (pick < 10)
                vals[CFG_FRAME_COUNT] = CFG_W'($urandom_range(1, 4));
            else if (pick < 15)
                vals[CFG_FRAME_COUNT] = 24'h1FFFFF;
            else if (pick < 20)
                vals[CFG_FRAME_COUNT] = CFG_W'(COUNT_MAX);
            else
                vals[CFG_FRAME_COUNT] = CFG_W'($urandom_range(200, 5000));

            for (int k = 0; k < NUM_EMISSION_REGS; k++)
                vals[CFG_EMISSION_0 + k] = pick_level();
            vals[CFG_UNUSED] = CFG_W'($urandom());

            // Some phases only change the levels and carry on integrating.
            mask = ($urandom_range(99) < 30) ? EMISSION_REGS : (TIMING_REGS | EMISSION_REGS);
            if ($urandom_range(99) < 25)
                mask[CFG_UNUSED] = 1'b1;

            // Short frames and a full budget so that the stalled sink backs up the block.
            if (phase == PRESSURE_PHASE)
            begin
                vals[CFG_FRAME_LENGTH] = CFG_W'($urandom_range(2, 8));
                vals[CFG_FRAME_OFFSET] = '0;
                vals[CFG_FRAME_COUNT]  = CFG_W'(COUNT_MAX);
                mask                   = TIMING_REGS | EMISSION_REGS;
            end
            program_regs(vals, mask);
            eff_len = scoreboard.effective_length();

            want_hold = want_hold || (phase == PRESSURE_PHASE);
            no_idle   = (phase == STEADY_PHASE);
            n_items   = (phase == PRESSURE_PHASE) ? 60 : $urandom_range(30, 80);
            repeat (n_items)
            begin
                if (phase == PRESSURE_PHASE)
                    send_segment(STATE_W'($urandom()),
                                 LEN_W'($urandom_range(0, 32'(6 * eff_len))));
                else
                    send_segment(STATE_W'($urandom()), pick_dwell(eff_len));
            end
            settle();
            no_idle = 1'b0;
            phase++;
        end

        $display("Sent %0d segments (%0d after the frame budget ran out) over %0d register settings.",
                 segments_sent, segments_ignored, settings_used);
        $display("Checked %0d frames; %0d segments were cut at %0d frames.",
                 scoreboard.frames_checked, scoreboard.clipped_segments, MAX_FRAMES);
        if (scoreboard.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Ends a run that hangs.
    initial
    begin : watchdog
        #60ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
